@@ hdl/rwps_pkg.sv @@
// shared types and codes for the rolling window percentile statistics block
`default_nettype none
package rwps_pkg;

  // input opcodes
  localparam logic [1:0] OP_RECORD = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam int CHAN_W = 4;
  localparam int DATA_W = 32;

  // command kinds after classification
  typedef enum logic [1:0] {
    CMD_RECORD,
    CMD_QUERY,
    CMD_CLEAR,
    CMD_EMPTY
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [CHAN_W-1:0]   chan;
    logic [DATA_W-1:0]   dur;
  } cmd_t;

  // result word, sample_count in the lowest bits
  typedef struct packed {
    logic [DATA_W-1:0] p95_ns;
    logic [DATA_W-1:0] median_ns;
    logic [DATA_W-1:0] last_ns;
    logic [DATA_W-1:0] mean_ns;
    logic [DATA_W-1:0] sample_count;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PDIV,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_MDIV,
    S_LAST,
    S_LASTCAP,
    S_OUT
  } state_t;

endpackage
`default_nettype wire

@@ hdl/rwps_front.sv @@
// input side: accepts words, classifies them and queues commands
`default_nettype none
module rwps_front #(
  parameter int LABELS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [1:0]            s_tuser,
  input  wire logic [39:0]           s_tdata,
  output logic                       cmd_valid,
  output rwps_pkg::cmd_t             cmd,
  input  wire logic                  cmd_pop
);
  import rwps_pkg::*;

  logic [CHAN_W-1:0] chan_in;
  logic [DATA_W-1:0] dur_in;
  logic              chan_ok;
  logic              push;
  cmd_t              cmd_in;
  cmd_t              q [2];
  logic              wptr;
  logic              rptr;
  logic [1:0]        cnt;

  assign chan_in = s_tdata[3:0];
  assign dur_in  = s_tdata[35:4];
  assign chan_ok = 32'(chan_in) < 32'(LABELS);

  // classify the incoming word
  always_comb begin
    cmd_in.chan = chan_in;
    cmd_in.dur  = dur_in;
    cmd_in.kind = CMD_EMPTY;
    push        = 1'b0;
    case (s_tuser)
      OP_RECORD: begin
        cmd_in.kind = CMD_RECORD;
        push        = chan_ok;
      end
      OP_QUERY: begin
        cmd_in.kind = chan_ok ? CMD_QUERY : CMD_EMPTY;
        push        = 1'b1;
      end
      OP_CLEAR: begin
        cmd_in.kind = CMD_CLEAR;
        push        = 1'b1;
      end
      default: push = 1'b0;
    endcase
  end

  assign s_tready  = (cnt != 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = q[rptr];

  // two entry command queue
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready && push) begin
      q[wptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (s_tvalid && s_tready && push) wptr <= ~wptr;
      if (cmd_pop) rptr <= ~rptr;
      cnt <= cnt + 2'(s_tvalid && s_tready && push) - 2'(cmd_pop);
    end
  end

endmodule
`default_nettype wire

@@ hdl/rwps_back.sv @@
// execution side: sample ring, per-channel counters, radix select and divider
`default_nettype none
module rwps_back #(
  parameter int WINDOW = 256,
  parameter int LABELS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cmd_valid,
  input  wire rwps_pkg::cmd_t        cmd,
  output logic                       cmd_pop,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output rwps_pkg::result_t          res
);
  import rwps_pkg::*;

  localparam int CW    = $clog2(WINDOW);
  localparam int VW    = $clog2(WINDOW + 1);
  localparam int LIW   = (LABELS > 1) ? $clog2(LABELS) : 1;
  localparam int DEPTH = LABELS * WINDOW;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = DATA_W + VW;
  localparam int DVW   = (VW > 7) ? VW : 7;
  localparam int DCW   = $clog2(SW + 1);
  // 95 * ceil(2^24 / 100): floor(v*95/100) is exact for v*95 below about 199000
  localparam logic [23:0] P95_MUL = 24'd15938435;

  state_t st, st_next;

  logic [CW-1:0]     cursor [LABELS];
  logic [DATA_W-1:0] total  [LABELS];
  logic [DATA_W-1:0] mem    [DEPTH];

  logic [LIW-1:0]    hidx;
  logic [CW-1:0]     cur_h;
  logic [DATA_W-1:0] tot_h;
  logic [VW-1:0]     valid_h;
  logic [AW-1:0]     base_h;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [DATA_W-1:0] rdata;
  logic              rvld;

  logic [AW-1:0]     base;
  logic [DATA_W-1:0] total_r;
  logic [CW-1:0]     cur_r;
  logic [CW-1:0]     lastpos;
  logic [VW-1:0]     valid_r;
  logic [VW-1:0]     idx;
  logic [4:0]        bitn;
  logic [DATA_W-1:0] mask;
  logic [DATA_W-1:0] pm;
  logic [DATA_W-1:0] pp;
  logic [VW-1:0]     km;
  logic [VW-1:0]     kp;
  logic [VW-1:0]     cm;
  logic [VW-1:0]     cp;
  logic [SW-1:0]     sum;
  logic [SW-1:0]     dvd;
  logic [DVW-1:0]    dvs;
  logic [DVW:0]      rem;
  logic [DCW-1:0]    dcnt;
  logic [DVW:0]      rem_sh;
  logic              qbit;
  logic              hit_m;
  logic              hit_p;
  logic [VW+23:0]    p95_prod;
  logic [VW-1:0]     p95_raw;
  logic [VW-1:0]     kp_h;

  // head command lookups
  assign hidx    = LIW'(cmd.chan);
  assign cur_h   = cursor[hidx];
  assign tot_h   = total[hidx];
  assign valid_h = (tot_h < 32'(WINDOW)) ? VW'(tot_h) : VW'(WINDOW);
  assign base_h  = AW'(32'(hidx) * 32'(WINDOW));
  assign lastpos = (cur_r == '0) ? CW'(WINDOW - 1) : cur_r - 1'b1;

  // p95 rank by reciprocal multiply, clamped to the last valid sample
  assign p95_prod = (VW+24)'(valid_h) * (VW+24)'(P95_MUL);
  assign p95_raw  = p95_prod[VW+23:24];
  assign kp_h     = (p95_raw >= valid_h) ? valid_h - 1'b1 : p95_raw;

  // divider step
  assign rem_sh = {rem[DVW-1:0], dvd[SW-1]};
  assign qbit   = (rem_sh >= {1'b0, dvs});

  // prefix match for both ranks
  assign hit_m = (((rdata ^ pm) & mask) == '0) && !rdata[bitn];
  assign hit_p = (((rdata ^ pp) & mask) == '0) && !rdata[bitn];

  // next state
  always_comb begin
    st_next = st;
    case (st)
      S_IDLE: begin
        if (cmd_valid) begin
          case (cmd.kind)
            CMD_QUERY: st_next = (valid_h == '0) ? S_OUT : S_PDIV;
            CMD_EMPTY: st_next = S_OUT;
            default:   st_next = S_IDLE;
          endcase
        end
      end
      S_PDIV:    st_next = S_SCAN;
      S_SCAN:    if (idx == valid_r - 1'b1) st_next = S_DRAIN;
      S_DRAIN:   st_next = S_DECIDE;
      S_DECIDE:  st_next = (bitn == 5'd0) ? S_MDIV : S_SCAN;
      S_MDIV:    if (dcnt == '0) st_next = S_LAST;
      S_LAST:    st_next = S_LASTCAP;
      S_LASTCAP: st_next = S_OUT;
      S_OUT:     if (m_tready) st_next = S_IDLE;
      default:   st_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    cmd_pop  = (st == S_IDLE) && cmd_valid;
    wr_en    = (st == S_IDLE) && cmd_valid && (cmd.kind == CMD_RECORD);
    wr_addr  = AW'(32'(base_h) + 32'(cur_h));
    m_tvalid = (st == S_OUT);
    rd_en    = (st == S_SCAN) || (st == S_LAST);
    rd_addr  = (st == S_LAST) ? AW'(32'(base) + 32'(lastpos)) : AW'(32'(base) + 32'(idx));
  end

  always_ff @(posedge clk) begin
    if (rst) st <= S_IDLE;
    else     st <= st_next;
  end

  // sample ring
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= cmd.dur;
    if (rd_en) rdata <= mem[rd_addr];
  end

  // per-channel cursor and count
  always_ff @(posedge clk) begin
    if (rst || (cmd_pop && cmd.kind == CMD_CLEAR)) begin
      for (int i = 0; i < LABELS; i++) begin
        cursor[i] <= '0;
        total[i]  <= '0;
      end
    end else if (wr_en) begin
      cursor[hidx] <= (cur_h == CW'(WINDOW - 1)) ? '0 : cur_h + 1'b1;
      if (tot_h != '1) total[hidx] <= tot_h + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) rvld <= 1'b0;
    else     rvld <= (st == S_SCAN);
  end

  // query datapath
  always_ff @(posedge clk) begin
    if (rvld) begin
      if (hit_m) cm <= cm + 1'b1;
      if (hit_p) cp <= cp + 1'b1;
      if (bitn == 5'd31) sum <= sum + SW'(rdata);
    end
    case (st)
      S_IDLE: begin
        if (cmd_valid) begin
          base    <= base_h;
          total_r <= tot_h;
          cur_r   <= cur_h;
          valid_r <= valid_h;
          km      <= valid_h >> 1;
          kp      <= kp_h;
          res     <= '0;
        end
      end
      S_PDIV: begin
        idx  <= '0;
        bitn <= 5'd31;
        mask <= '0;
        pm   <= '0;
        pp   <= '0;
        cm   <= '0;
        cp   <= '0;
        sum  <= '0;
      end
      S_MDIV: begin
        if (dcnt != '0) begin
          rem  <= qbit ? rem_sh - {1'b0, dvs} : rem_sh;
          dvd  <= {dvd[SW-2:0], qbit};
          dcnt <= dcnt - 1'b1;
        end else begin
          res.mean_ns <= dvd[DATA_W-1:0];
        end
      end
      S_SCAN: idx <= idx + 1'b1;
      S_DECIDE: begin
        if (km >= cm) begin
          pm[bitn] <= 1'b1;
          km       <= km - cm;
        end
        if (kp >= cp) begin
          pp[bitn] <= 1'b1;
          kp       <= kp - cp;
        end
        mask <= {1'b1, mask[DATA_W-1:1]};
        bitn <= bitn - 1'b1;
        idx  <= '0;
        cm   <= '0;
        cp   <= '0;
        dvd  <= sum;
        dvs  <= DVW'(valid_r);
        rem  <= '0;
        dcnt <= DCW'(SW);
      end
      S_LASTCAP: begin
        res.last_ns      <= rdata;
        res.median_ns    <= pm;
        res.p95_ns       <= pp;
        res.sample_count <= total_r;
      end
      default: ;
    endcase
  end

  a_rvld_scan: assert property (@(posedge clk) disable iff (rst)
    rvld |-> (st == S_SCAN || st == S_DRAIN))
    else $error("read data outside a scan pass");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (st == S_SCAN) |-> (idx < valid_r))
    else $error("scan index past valid samples");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> (st == S_IDLE && cmd_valid))
    else $error("command taken while busy");

endmodule
`default_nettype wire

@@ hdl/rolling_window_percentile_stats.sv @@
// top level: rolling window duration statistics per channel
//
// channel  dir  fields (lowest bit first)
// s_*      in   tuser: opcode[1:0]; tdata: channel[3:0], duration_ns[35:4]
// m_*      out  tdata: sample_count, mean_ns, last_ns, median_ns, p95_ns
//
// record and clear are taken straight from idle in the back part; a query
// on a channel with v valid samples runs the 32 radix select passes over
// the sample memory read port plus one serial division for the mean before
// its result. an empty query answers with no scan and no division.
// synchronous reset clears cursors and counts; the sample ring is not cleared.
// the two entry command queue keeps taking words while a result stalls, until it is full.
`default_nettype none
module rolling_window_percentile_stats #(
  parameter int WINDOW = 256,
  parameter int LABELS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [1:0]   s_tuser,   // opcode
  input  wire logic [39:0]  s_tdata,   // channel, duration_ns, zero pad
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [159:0]      m_tdata    // sample_count, mean_ns, last_ns, median_ns, p95_ns
);
  import rwps_pkg::*;

  logic    cmd_valid;
  cmd_t    cmd;
  logic    cmd_pop;
  result_t res;

  rwps_front #(.LABELS(LABELS)) u_front (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
  );

  rwps_back #(.WINDOW(WINDOW), .LABELS(LABELS)) u_back (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .res(res)
  );

  assign m_tdata = res;

endmodule
`default_nettype wire
